[rtl/itp_pkg.sv]
// Package for the infix-to-postfix converter: stack sizing, character
// codes, operator classes and precedence helpers. No dependencies.
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef logic [7:0]       char_t;
  typedef logic [CNT_W-1:0] count_t;

  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_MUL   = 8'h2A;
  localparam char_t CH_DIV   = 8'h2F;
  localparam char_t CH_MOD   = 8'h25;
  localparam char_t CH_POW   = 8'h5E;
  localparam char_t CH_OPEN  = 8'h28;
  localparam char_t CH_CLOSE = 8'h29;
  localparam char_t CH_SPACE = 8'h20;

  // Character classes.
  typedef logic [2:0] cls_t;
  localparam cls_t CLS_SKIP    = 3'd0;
  localparam cls_t CLS_OPERAND = 3'd1;
  localparam cls_t CLS_ADD     = 3'd2;
  localparam cls_t CLS_MUL     = 3'd3;
  localparam cls_t CLS_POW     = 3'd4;
  localparam cls_t CLS_CLOSE   = 3'd5;

  // Pop levels: how far down the stack an operator may pop.
  typedef logic [1:0] lvl_t;
  localparam lvl_t LVL_PAREN = 2'd0;
  localparam lvl_t LVL_ADD   = 2'd1;
  localparam lvl_t LVL_MUL   = 2'd2;

  // Control handed from the sequencer to the stack cells.
  typedef struct packed {
    logic  push;
    logic  pop;
    char_t din;
  } stk_ctrl_t;

  function automatic cls_t classify(input char_t c);
    cls_t r;
    case (c)
      CH_SPACE:                 r = CLS_SKIP;
      CH_PLUS, CH_MINUS:        r = CLS_ADD;
      CH_MUL, CH_DIV, CH_MOD:   r = CLS_MUL;
      CH_POW:                   r = CLS_POW;
      CH_CLOSE:                 r = CLS_CLOSE;
      default:                  r = CLS_OPERAND;
    endcase
    return r;
  endfunction

  function automatic lvl_t cls_level(input cls_t c);
    lvl_t r;
    case (c)
      CLS_MUL: r = LVL_ADD;
      CLS_POW: r = LVL_MUL;
      default: r = LVL_PAREN;
    endcase
    return r;
  endfunction

  function automatic logic stops_at(input char_t t, input lvl_t lvl);
    logic r;
    r = (t == CH_OPEN);
    if (lvl >= LVL_ADD && (t == CH_PLUS || t == CH_MINUS)) r = 1'b1;
    if (lvl >= LVL_MUL && (t == CH_MUL || t == CH_DIV || t == CH_MOD)) r = 1'b1;
    return r;
  endfunction

endpackage

[rtl/itp_cell.sv]
// One stack cell: holds one entry and shifts with its neighbors.
// Depends on itp_pkg.
module itp_cell (
  input  logic                clk,
  input  itp_pkg::stk_ctrl_t  ctrl,
  input  itp_pkg::char_t      from_above,
  input  itp_pkg::char_t      from_below,
  output itp_pkg::char_t      data
);
  import itp_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      data <= from_above;
    end else if (ctrl.pop) begin
      data <= from_below;
    end
  end

endmodule

[rtl/itp_stack.sv]
// Operator stack built as a row of shifting cells; cell 0 is the top.
// Depends on itp_pkg and itp_cell.
module itp_stack (
  input  logic                clk,
  input  itp_pkg::stk_ctrl_t  ctrl,
  output itp_pkg::char_t      top
);
  import itp_pkg::*;

  char_t cells [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    char_t above;
    char_t below;
    if (i == 0) begin : g_first
      assign above = ctrl.din;
    end else begin : g_mid
      assign above = cells[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_end
      assign below = '0;
    end else begin : g_inner
      assign below = cells[i+1];
    end
    itp_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .from_above (above),
      .from_below (below),
      .data       (cells[i])
    );
  end

  assign top = cells[0];

endmodule

[rtl/infix_to_postfix_converter.sv]
// Top level of the infix-to-postfix converter (shunting yard).
// Depends on itp_pkg and itp_stack.
//
//  Channel | Dir | Signals                          | Contents
//  s       | in  | s_tvalid s_tready s_tdata s_tlast | one infix character
//  m       | out | m_tvalid m_tready m_tdata m_tlast | one postfix character
//
// An ordinary character is accepted in S_IDLE, pushed in S_SCAN and closed
// in S_END, which releases the held result if there is one. Each entry
// popped by an operator or ')' adds a step in S_SCAN, since the stack cells
// shift one place per pop; after the last character the implicit ')' adds
// the S_DRAIN state, which pops its entries one at a time.
// Reset clears the sequencer, the stack count and the overflow flag; the
// cells themselves are not cleared. A stalled output holds the sequencer in
// place; a new input transaction is taken only when the previous one is done.
module infix_to_postfix_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_char
  input  logic        s_tlast,   // in_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_char, [8] no_char, [9] overflow
  output logic        m_tlast    // out_last
);
  import itp_pkg::*;

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a character
  localparam logic [1:0] S_SCAN  = 2'd1;  // pops for the character, then push
  localparam logic [1:0] S_DRAIN = 2'd2;  // implicit ')' after the last one
  localparam logic [1:0] S_END   = 2'd3;  // release the held result

  logic [1:0] state, state_next;
  count_t     count, count_next;
  logic       ovf, ovf_next;

  // Current character.
  char_t ch, ch_next;
  cls_t  cls, cls_next;
  logic  ch_last, ch_last_next;

  // One result is held back so that the final one of an expression can be
  // marked last once it is known that nothing follows it.
  logic  held_valid, held_valid_next;
  char_t held_char, held_char_next;
  logic  held_ovf, held_ovf_next;

  // Output register.
  logic  m_tvalid_next;
  char_t out_char, out_char_next;
  logic  out_none, out_none_next;
  logic  out_ovf, out_ovf_next;
  logic  m_tlast_next;

  stk_ctrl_t ctrl;
  char_t     top;
  lvl_t      lvl;
  logic      can_pop;
  logic      out_free;
  logic      emit_ok;

  itp_stack u_stack (
    .clk  (clk),
    .ctrl (ctrl),
    .top  (top)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {6'b0, out_ovf, out_none, out_char};
  assign out_free = !m_tvalid || m_tready;
  // A new result can be produced when the held slot is empty or can move on.
  assign emit_ok  = !held_valid || out_free;
  assign lvl      = (state == S_DRAIN) ? LVL_PAREN : cls_level(cls);
  // An empty stack reads as the base '(' and stops every pop.
  assign can_pop  = (count != '0) && !stops_at(top, lvl);

  always_comb begin
    state_next      = state;
    count_next      = count;
    ovf_next        = ovf;
    ch_next         = ch;
    cls_next        = cls;
    ch_last_next    = ch_last;
    held_valid_next = held_valid;
    held_char_next  = held_char;
    held_ovf_next   = held_ovf;
    m_tvalid_next   = m_tvalid && !m_tready;
    out_char_next   = out_char;
    out_none_next   = out_none;
    out_ovf_next    = out_ovf;
    m_tlast_next    = m_tlast;
    ctrl            = '0;
    ctrl.din        = ch;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          ch_next      = s_tdata;
          cls_next     = classify(s_tdata);
          ch_last_next = s_tlast;
          state_next   = S_SCAN;
        end
      end

      S_SCAN, S_DRAIN: begin
        if (can_pop && (state == S_DRAIN || (cls != CLS_SKIP && cls != CLS_OPERAND))) begin
          if (emit_ok) begin
            if (held_valid) begin
              m_tvalid_next = 1'b1;
              out_char_next = held_char;
              out_none_next = 1'b0;
              out_ovf_next  = held_ovf;
              m_tlast_next  = 1'b0;
            end
            held_valid_next = 1'b1;
            held_char_next  = top;
            held_ovf_next   = ovf;
            ctrl.pop        = 1'b1;
            count_next      = count - count_t'(1);
          end
        end else if (state == S_DRAIN) begin
          // The '(' that stopped the drain and everything under it go away.
          count_next = '0;
          state_next = S_END;
        end else begin
          if (cls == CLS_CLOSE) begin
            if (count != '0) begin
              ctrl.pop   = 1'b1;
              count_next = count - count_t'(1);
            end
          end else if (cls != CLS_SKIP) begin
            if (count < count_t'(STACK_DEPTH)) begin
              ctrl.push  = 1'b1;
              count_next = count + count_t'(1);
            end else begin
              ovf_next = 1'b1;
            end
          end
          state_next = ch_last ? S_DRAIN : S_END;
        end
      end

      S_END: begin
        if (held_valid) begin
          if (out_free) begin
            m_tvalid_next   = 1'b1;
            out_char_next   = held_char;
            out_none_next   = 1'b0;
            out_ovf_next    = held_ovf;
            m_tlast_next    = ch_last;
            held_valid_next = 1'b0;
            state_next      = S_IDLE;
          end
        end else if (ch_last) begin
          // Nothing came out of the last character: send the bare end mark.
          if (out_free) begin
            m_tvalid_next = 1'b1;
            out_char_next = '0;
            out_none_next = 1'b1;
            out_ovf_next  = ovf;
            m_tlast_next  = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      ovf        <= 1'b0;
      held_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      ovf        <= ovf_next;
      held_valid <= held_valid_next;
      m_tvalid   <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    ch        <= ch_next;
    cls       <= cls_next;
    ch_last   <= ch_last_next;
    held_char <= held_char_next;
    held_ovf  <= held_ovf_next;
    out_char  <= out_char_next;
    out_none  <= out_none_next;
    out_ovf   <= out_ovf_next;
    m_tlast   <= m_tlast_next;
  end

`ifndef SYNTHESIS
  // The stack never holds more entries than it has cells.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(STACK_DEPTH))
    else $error("stack count above depth");

  // Every held result is released before a new character is taken.
  a_held_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !held_valid)
    else $error("held result left behind at end of character");

  // A bare end mark is always the final transaction of an expression.
  a_mark_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[8]) |-> m_tlast)
    else $error("end mark not marked last");

  // After the final character the stack is empty.
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_END && ch_last) |-> (count == '0))
    else $error("stack not cleared at end of expression");
`endif

endmodule
